### src/sdcl_pkg.sv
// Shared types, codes and CRC7 helper for the SD CMD line engine.
package sdcl_pkg;

  localparam int FRAME_W   = 40;
  localparam int TX_W      = 48;
  localparam int CMD_BITS  = 40;
  localparam int SHORT_LEN = 6;
  localparam int LONG_LEN  = 17;

  localparam logic [6:0] CRC_POLY = 7'h09;

  // func codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // response kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_R1   = 3'd1;
  localparam logic [2:0] KIND_R2   = 3'd2;
  localparam logic [2:0] KIND_R3   = 3'd3;
  localparam logic [2:0] KIND_R6   = 3'd4;

  // completion status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_TIMEOUT = 2'd2;
  localparam logic [1:0] ST_CRC_ERR = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_TX   = 3'd1,
    PH_TURN = 3'd2,
    PH_WAIT = 3'd3,
    PH_RX   = 3'd4
  } phase_t;

  typedef struct packed {
    logic                func;
    logic [FRAME_W-1:0]  cmd_frame;
    logic [2:0]          response_kind;
    logic                cmd_sample;
  } in_t;

  typedef struct packed {
    logic       cmd_drive;
    logic       cmd_output_enable;
    logic [7:0] response_byte;
    logic       byte_valid;
    logic [4:0] byte_index;
    logic       done_res;
    logic [1:0] status;
  } out_t;

  // one CRC7 step, x^7 + x^3 + 1, MSB first
  function automatic logic [6:0] crc7_bit(input logic [6:0] c, input logic b);
    logic [6:0] n;
    n = {c[5:0], 1'b0};
    if (c[6] ^ b) begin
      n = n ^ CRC_POLY;
    end
    return n;
  endfunction

endpackage

### src/sdcl_core.sv
// CMD line sequencer: command shift-out with CRC7, turnaround, response capture.
module sdcl_core #(
  parameter int START_TIMEOUT    = 101,
  parameter int TURNAROUND_TICKS = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step_en,
  input  sdcl_pkg::in_t in_data,
  output sdcl_pkg::out_t res
);

  sdcl_pkg::phase_t phase_r, phase_nxt;
  logic [sdcl_pkg::TX_W-1:0] tx_shift_r, tx_shift_nxt;
  logic [5:0] bit_count_r, bit_count_nxt;
  logic [6:0] crc_r, crc_nxt;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic [4:0] rx_index_r, rx_index_nxt;
  logic [6:0] wait_count_r, wait_count_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic       busy_r, busy_nxt;

  // shared terms
  logic       tx_bit;
  logic [5:0] cnt_inc;
  logic [7:0] rx_shift;
  logic [4:0] last_index;
  logic       rx_last;
  logic       byte_done;
  logic       timeout_hit;
  logic       crc_checked;

  always_comb begin
    tx_bit      = tx_shift_r[sdcl_pkg::TX_W-1];
    cnt_inc     = bit_count_r + 6'd1;
    rx_shift    = {rx_byte_r[6:0], in_data.cmd_sample};
    last_index  = (kind_r == sdcl_pkg::KIND_R2) ? 5'(sdcl_pkg::LONG_LEN - 1)
                                                : 5'(sdcl_pkg::SHORT_LEN - 1);
    rx_last     = rx_index_r >= last_index;
    byte_done   = cnt_inc >= 6'd8;
    timeout_hit = wait_count_r >= 7'(START_TIMEOUT);
    crc_checked = (kind_r == sdcl_pkg::KIND_R1) || (kind_r == sdcl_pkg::KIND_R6);
  end

  // next state
  always_comb begin
    phase_nxt      = phase_r;
    tx_shift_nxt   = tx_shift_r;
    bit_count_nxt  = bit_count_r;
    crc_nxt        = crc_r;
    rx_byte_nxt    = rx_byte_r;
    rx_index_nxt   = rx_index_r;
    wait_count_nxt = wait_count_r;
    kind_nxt       = kind_r;
    busy_nxt       = busy_r;
    if (in_data.func == sdcl_pkg::FUNC_START) begin
      // a start abandons whatever is in flight
      phase_nxt      = sdcl_pkg::PH_TX;
      tx_shift_nxt   = {in_data.cmd_frame, 8'h00};
      bit_count_nxt  = '0;
      crc_nxt        = '0;
      rx_byte_nxt    = '0;
      rx_index_nxt   = '0;
      wait_count_nxt = '0;
      kind_nxt       = in_data.response_kind;
      busy_nxt       = 1'b0;
    end else begin
      unique case (phase_r)
        sdcl_pkg::PH_IDLE: begin
        end
        sdcl_pkg::PH_TX: begin
          if (bit_count_r < 6'(sdcl_pkg::CMD_BITS)) begin
            crc_nxt = sdcl_pkg::crc7_bit(crc_r, tx_bit);
          end
          tx_shift_nxt  = {tx_shift_r[sdcl_pkg::TX_W-2:0], 1'b0};
          bit_count_nxt = cnt_inc;
          // append CRC and stop bit behind the command bits
          if (cnt_inc == 6'(sdcl_pkg::CMD_BITS)) begin
            tx_shift_nxt[sdcl_pkg::TX_W-1 -: 8] = {crc_nxt, 1'b1};
          end
          if (cnt_inc >= 6'(sdcl_pkg::TX_W)) begin
            bit_count_nxt  = '0;
            wait_count_nxt = '0;
            if (kind_r == sdcl_pkg::KIND_NONE) begin
              phase_nxt = sdcl_pkg::PH_IDLE;
            end else if (TURNAROUND_TICKS == 0) begin
              phase_nxt = sdcl_pkg::PH_WAIT;
            end else begin
              phase_nxt = sdcl_pkg::PH_TURN;
            end
          end
        end
        sdcl_pkg::PH_TURN: begin
          bit_count_nxt = cnt_inc;
          if (cnt_inc >= 6'(TURNAROUND_TICKS)) begin
            phase_nxt      = sdcl_pkg::PH_WAIT;
            bit_count_nxt  = '0;
            wait_count_nxt = '0;
          end
        end
        sdcl_pkg::PH_WAIT: begin
          if (!in_data.cmd_sample) begin
            // start bit counts as bit 0 of byte 0; CRC of a zero bit stays zero
            phase_nxt     = sdcl_pkg::PH_RX;
            rx_byte_nxt   = '0;
            bit_count_nxt = 6'd1;
            rx_index_nxt  = '0;
            crc_nxt       = '0;
          end else if (timeout_hit) begin
            phase_nxt = sdcl_pkg::PH_IDLE;
          end else begin
            wait_count_nxt = wait_count_r + 7'd1;
          end
        end
        sdcl_pkg::PH_RX: begin
          rx_byte_nxt = rx_shift;
          if (!rx_last) begin
            crc_nxt = sdcl_pkg::crc7_bit(crc_r, in_data.cmd_sample);
          end
          bit_count_nxt = cnt_inc;
          if (byte_done) begin
            bit_count_nxt = '0;
            if ((kind_r == sdcl_pkg::KIND_R3) && (rx_index_r == 5'd1) && !rx_shift[7]) begin
              busy_nxt = 1'b1;
            end
            if (rx_last) begin
              phase_nxt = sdcl_pkg::PH_IDLE;
            end else begin
              rx_index_nxt = rx_index_r + 5'd1;
              rx_byte_nxt  = '0;
            end
          end
        end
        default: begin
          phase_nxt = sdcl_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // per-tick result
  always_comb begin
    res = '0;
    res.cmd_drive = 1'b1;
    unique case (phase_r)
      sdcl_pkg::PH_IDLE, sdcl_pkg::PH_TURN: begin
      end
      sdcl_pkg::PH_TX: begin
        res.cmd_drive         = tx_bit;
        res.cmd_output_enable = 1'b1;
        res.done_res          = (cnt_inc >= 6'(sdcl_pkg::TX_W)) &&
                                (kind_r == sdcl_pkg::KIND_NONE);
      end
      sdcl_pkg::PH_WAIT: begin
        if (in_data.cmd_sample && timeout_hit) begin
          res.done_res = 1'b1;
          res.status   = sdcl_pkg::ST_TIMEOUT;
        end
      end
      sdcl_pkg::PH_RX: begin
        if (byte_done) begin
          res.response_byte = rx_shift;
          res.byte_valid    = 1'b1;
          res.byte_index    = rx_index_r;
          if (rx_last) begin
            res.done_res = 1'b1;
            if (crc_checked && (rx_shift != {crc_r, 1'b1})) begin
              res.status = sdcl_pkg::ST_CRC_ERR;
            end else if (busy_r) begin
              res.status = sdcl_pkg::ST_BUSY;
            end else begin
              res.status = sdcl_pkg::ST_OK;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sdcl_pkg::PH_IDLE;
      tx_shift_r   <= '0;
      bit_count_r  <= '0;
      crc_r        <= '0;
      rx_byte_r    <= '0;
      rx_index_r   <= '0;
      wait_count_r <= '0;
      kind_r       <= '0;
      busy_r       <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      tx_shift_r   <= tx_shift_nxt;
      bit_count_r  <= bit_count_nxt;
      crc_r        <= crc_nxt;
      rx_byte_r    <= rx_byte_nxt;
      rx_index_r   <= rx_index_nxt;
      wait_count_r <= wait_count_nxt;
      kind_r       <= kind_nxt;
      busy_r       <= busy_nxt;
    end
  end

endmodule

### src/sd_cmd_line_engine_top.sv
// Top level of the SD CMD line engine: handshakes, result register, checks.
// One transaction on the input channel is either a start (load a 40-bit
// command and response kind, no result) or one SD clock tick (exactly one
// result). For each transaction the sequencer state and the
// result register both update at the accepting edge, so a new transaction is
// taken every cycle as long as the result register is empty or being drained
// in the same cycle. A tick shifts out one command bit (MSB first, then CRC7
// and the stop bit), counts turnaround, samples for the start bit (timeout
// after START_TIMEOUT+1 high samples) or shifts in one response bit; a byte
// shows up with byte_valid on the tick that completes it, and done_res with
// status marks the tick on which the engine returns to idle.
module sd_cmd_line_engine_top #(
  parameter int START_TIMEOUT    = 101,
  parameter int TURNAROUND_TICKS = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  sdcl_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sdcl_pkg::out_t out_data
);

  logic           in_fire;
  logic           tick_fire;
  sdcl_pkg::out_t step_res;
  sdcl_pkg::out_t out_r, out_nxt;
  logic           out_valid_r, out_valid_nxt;

  // result register frees up when empty or drained this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign tick_fire = in_fire && (in_data.func == sdcl_pkg::FUNC_TICK);

  sdcl_core #(
    .START_TIMEOUT    (START_TIMEOUT),
    .TURNAROUND_TICKS (TURNAROUND_TICKS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_fire),
    .in_data (in_data),
    .res     (step_res)
  );

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (tick_fire) begin
      out_nxt       = step_res;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // every accepted tick leaves a result behind
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    tick_fire |=> out_valid)
    else $error("tick transaction produced no result");

  // a received byte never coincides with the host driving the line
  a_rx_not_driving: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.byte_valid) |-> !out_data.cmd_output_enable)
    else $error("response byte while host drives CMD");

  // non-ok status only on completion
  a_status_with_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != sdcl_pkg::ST_OK)) |-> out_data.done_res)
    else $error("status without done_res");

  // byte index stays inside the longest response
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.byte_valid) |->
      (out_data.byte_index <= 5'(sdcl_pkg::LONG_LEN - 1)))
    else $error("byte index out of range");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for the SD CMD line engine: command framing, CRC7, response capture.
module testbench;

  // Engine timing used for both the DUT and the local prediction.
  localparam int TOUT_TICKS = 101;
  localparam int TURN_TICKS = 2;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  sdcl_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  sdcl_pkg::out_t out_data;

  sd_cmd_line_engine_top #(
    .START_TIMEOUT    (TOUT_TICKS),
    .TURNAROUND_TICKS (TURN_TICKS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Predicted engine state, advanced once per accepted input transaction.
  sdcl_pkg::phase_t eng_phase;
  logic [47:0]      eng_shift;
  logic [7:0]       eng_bits;
  logic [6:0]       eng_crc;
  logic [7:0]       eng_rx_byte;
  logic [4:0]       eng_rx_idx;
  logic [6:0]       eng_wait;
  logic [2:0]       eng_kind;
  logic             eng_busy;

  // Line results predicted but not yet seen on the result channel, oldest first.
  sdcl_pkg::out_t pending_results[$];

  bit idle_on;   // sender inserts idle bursts
  bit stall_on;  // receiver inserts stall bursts
  int fail_count;
  int items_sent;
  int commands_sent;
  int bytes_seen;
  int status_seen[4];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // CRC7 over x^7 + x^3 + 1, one bit at a time, MSB first.
  function automatic logic [6:0] crc7_next(input logic [6:0] c, input logic d);
    logic fb;
    fb = c[6] ^ d;
    return {c[5:3], c[2] ^ fb, c[1:0], fb};
  endfunction

  function automatic logic [39:0] rand_frame();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[39:0];
  endfunction

  function automatic string show_result(input sdcl_pkg::out_t r);
    return $sformatf("drive=%0d oe=%0d byte=%02h valid=%0d idx=%0d done=%0d status=%0d",
                     r.cmd_drive, r.cmd_output_enable, r.response_byte, r.byte_valid,
                     r.byte_index, r.done_res, r.status);
  endfunction

  task automatic report_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endtask

  task automatic reset_line_engine();
    eng_phase   = sdcl_pkg::PH_IDLE;
    eng_shift   = '0;
    eng_bits    = '0;
    eng_crc     = '0;
    eng_rx_byte = '0;
    eng_rx_idx  = '0;
    eng_wait    = '0;
    eng_kind    = '0;
    eng_busy    = 1'b0;
  endtask

  // Advance the predicted engine by one transaction. A start yields no result,
  // every tick yields exactly one.
  task automatic advance_line_engine(input sdcl_pkg::in_t it, output bit made,
                                     output sdcl_pkg::out_t res);
    logic b;
    int   total;
    res = '0;
    res.cmd_drive = 1'b1;
    made = 1'b0;
    total = sdcl_pkg::SHORT_LEN;
    if (it.func == sdcl_pkg::FUNC_START) begin
      // a start always wins, even over a transfer in flight
      eng_phase   = sdcl_pkg::PH_TX;
      eng_shift   = {it.cmd_frame, 8'h00};
      eng_bits    = '0;
      eng_crc     = '0;
      eng_rx_byte = '0;
      eng_rx_idx  = '0;
      eng_wait    = '0;
      eng_kind    = it.response_kind;
      eng_busy    = 1'b0;
    end else begin
      made = 1'b1;
      case (eng_phase)
        sdcl_pkg::PH_TX: begin
          b = eng_shift[47];
          res.cmd_drive = b;
          res.cmd_output_enable = 1'b1;
          if (eng_bits < sdcl_pkg::CMD_BITS) begin
            eng_crc = crc7_next(eng_crc, b);
          end
          eng_shift = eng_shift << 1;
          eng_bits++;
          // after the command bits, the CRC and stop bit take the top byte
          if (eng_bits == sdcl_pkg::CMD_BITS) begin
            eng_shift[47:40] = {eng_crc, 1'b1};
          end
          if (eng_bits >= sdcl_pkg::TX_W) begin
            eng_bits = '0;
            eng_wait = '0;
            if (eng_kind == sdcl_pkg::KIND_NONE) begin
              eng_phase = sdcl_pkg::PH_IDLE;
              res.done_res = 1'b1;
            end else if (TURN_TICKS == 0) begin
              eng_phase = sdcl_pkg::PH_WAIT;
            end else begin
              eng_phase = sdcl_pkg::PH_TURN;
            end
          end
        end
        sdcl_pkg::PH_TURN: begin
          eng_bits++;
          if (eng_bits >= TURN_TICKS) begin
            eng_phase = sdcl_pkg::PH_WAIT;
            eng_bits  = '0;
            eng_wait  = '0;
          end
        end
        sdcl_pkg::PH_WAIT: begin
          if (!it.cmd_sample) begin
            eng_phase   = sdcl_pkg::PH_RX;
            eng_rx_byte = '0;
            eng_bits    = 8'd1;
            eng_rx_idx  = '0;
            eng_crc     = '0;
          end else if (eng_wait >= TOUT_TICKS) begin
            eng_phase = sdcl_pkg::PH_IDLE;
            res.done_res = 1'b1;
            res.status = sdcl_pkg::ST_TIMEOUT;
          end else begin
            eng_wait++;
          end
        end
        sdcl_pkg::PH_RX: begin
          if (eng_kind == sdcl_pkg::KIND_R2) begin
            total = sdcl_pkg::LONG_LEN;
          end
          eng_rx_byte = {eng_rx_byte[6:0], it.cmd_sample};
          if (eng_rx_idx < total - 1) begin
            eng_crc = crc7_next(eng_crc, it.cmd_sample);
          end
          eng_bits++;
          if (eng_bits >= 8) begin
            res.response_byte = eng_rx_byte;
            res.byte_valid = 1'b1;
            res.byte_index = eng_rx_idx;
            if (eng_kind == sdcl_pkg::KIND_R3 && eng_rx_idx == 1 && !eng_rx_byte[7]) begin
              eng_busy = 1'b1;
            end
            if (eng_rx_idx >= total - 1) begin
              res.done_res = 1'b1;
              if ((eng_kind == sdcl_pkg::KIND_R1 || eng_kind == sdcl_pkg::KIND_R6) &&
                  eng_rx_byte != {eng_crc, 1'b1}) begin
                res.status = sdcl_pkg::ST_CRC_ERR;
              end else if (eng_busy) begin
                res.status = sdcl_pkg::ST_BUSY;
              end
              eng_phase = sdcl_pkg::PH_IDLE;
              eng_bits  = '0;
            end else begin
              eng_rx_idx++;
              eng_bits    = '0;
              eng_rx_byte = '0;
            end
          end
        end
        default: begin
          eng_phase = sdcl_pkg::PH_IDLE;
        end
      endcase
    end
  endtask

  // Send one transaction; called and returns at a rising edge. Prediction is
  // done at the accepting edge.
  task automatic send_item(input sdcl_pkg::in_t it);
    bit             made;
    sdcl_pkg::out_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    advance_line_engine(it, made, res);
    if (made) begin
      pending_results.push_back(res);
    end
    items_sent++;
  endtask

  // A tick carries random frame and kind bits, which the engine ignores.
  task automatic send_tick(input logic smp);
    sdcl_pkg::in_t it;
    it.func          = sdcl_pkg::FUNC_TICK;
    it.cmd_frame     = rand_frame();
    it.response_kind = 3'($urandom_range(0, 7));
    it.cmd_sample    = smp;
    send_item(it);
  endtask

  // One command: start, then the ticks of the whole exchange. gap is the number
  // of high samples before the start bit (past the timeout it ends there),
  // flaw flips one response bit after the start bit, cut (if not negative)
  // stops after that many ticks so the next start abandons the transfer.
  task automatic run_command(input logic [39:0] frame, input logic [2:0] kind,
                             input int gap, input bit flaw, input int cut);
    sdcl_pkg::in_t st;
    bit            line_bits[$];
    logic [7:0]    resp[sdcl_pkg::LONG_LEN];
    logic [6:0]    c;
    int            total;
    int            i;
    int            j;
    int            n;
    int            pos;
    st.func          = sdcl_pkg::FUNC_START;
    st.cmd_frame     = frame;
    st.response_kind = kind;
    st.cmd_sample    = 1'($urandom_range(0, 1));
    send_item(st);
    commands_sent++;
    // samples during the command phase are don't-care
    for (i = 0; i < sdcl_pkg::TX_W; i++) begin
      line_bits.push_back(1'($urandom_range(0, 1)));
    end
    if (kind != sdcl_pkg::KIND_NONE) begin
      for (i = 0; i < TURN_TICKS; i++) begin
        line_bits.push_back(1'($urandom_range(0, 1)));
      end
      if (gap > TOUT_TICKS) begin
        for (i = 0; i <= TOUT_TICKS; i++) begin
          line_bits.push_back(1'b1);
        end
      end else begin
        for (i = 0; i < gap; i++) begin
          line_bits.push_back(1'b1);
        end
        total = (kind == sdcl_pkg::KIND_R2) ? sdcl_pkg::LONG_LEN : sdcl_pkg::SHORT_LEN;
        for (i = 0; i < total; i++) begin
          resp[i] = 8'($urandom_range(0, 255));
        end
        resp[0][7] = 1'b0;  // start bit
        if (kind == sdcl_pkg::KIND_R1 || kind == sdcl_pkg::KIND_R6) begin
          c = '0;
          for (i = 0; i < total - 1; i++) begin
            for (j = 7; j >= 0; j--) begin
              c = crc7_next(c, resp[i][j]);
            end
          end
          resp[total-1] = {c, 1'b1};
        end
        for (i = 0; i < total; i++) begin
          for (j = 7; j >= 0; j--) begin
            line_bits.push_back(resp[i][j]);
          end
        end
        if (flaw) begin
          pos = line_bits.size() - $urandom_range(1, total * 8 - 1);
          line_bits[pos] = ~line_bits[pos];
        end
      end
    end
    n = line_bits.size();
    if (cut >= 0 && cut < n) begin
      n = cut;
    end
    for (i = 0; i < n; i++) begin
      send_tick(line_bits[i]);
    end
  endtask

  // Hold the sender until every predicted result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Ticks with nothing loaded only release the line.
  task automatic test_idle_ticks();
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
  endtask

  // Start while busy, then a no-response command with an all-ones frame.
  task automatic test_abandon_no_response();
    run_command({40{1'b1}}, sdcl_pkg::KIND_R1, 0, 1'b0, 5);
    run_command({40{1'b1}}, sdcl_pkg::KIND_NONE, 0, 1'b0, -1);
    send_tick(1'b1);
  endtask

  // Card-busy check on R3, and an unchecked response of an unused kind.
  task automatic test_short_responses();
    run_command(rand_frame(), sdcl_pkg::KIND_R3, 1, 1'b0, -1);
    run_command(rand_frame(), 3'd7, 0, 1'b1, -1);
  endtask

  task automatic test_long_response();
    run_command(rand_frame(), sdcl_pkg::KIND_R2, 4, 1'b0, -1);
  endtask

  // Start bit on the last sample before the timeout, then one too late.
  task automatic test_start_timeout();
    run_command(rand_frame(), sdcl_pkg::KIND_R1, TOUT_TICKS, 1'b0, -1);
    run_command(rand_frame(), sdcl_pkg::KIND_R6, TOUT_TICKS + 1, 1'b0, -1);
  endtask

  // All-zero frame with no response, then the sender pauses with the pipe empty.
  task automatic test_drain_pause();
    run_command('0, sdcl_pkg::KIND_NONE, 0, 1'b0, -1);
    wait_drained();
  endtask

  // No idling on either side: one transaction per clock, corrupted R6 CRC.
  task automatic test_full_rate();
    idle_on  = 1'b0;
    stall_on = 1'b0;
    run_command(rand_frame(), sdcl_pkg::KIND_R6, 2, 1'b1, -1);
  endtask

  // Receiver: ready mostly high, with random stall bursts while enabled.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Result checker: every accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    sdcl_pkg::out_t want;
    string          bad;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_fail($sformatf("result with none predicted: %s", show_result(out_data)));
      end else begin
        want = pending_results.pop_front();
        bad = "";
        if (out_data.cmd_drive != want.cmd_drive) bad = {bad, " cmd_drive"};
        if (out_data.cmd_output_enable != want.cmd_output_enable) bad = {bad, " cmd_output_enable"};
        if (out_data.response_byte != want.response_byte) bad = {bad, " response_byte"};
        if (out_data.byte_valid != want.byte_valid) bad = {bad, " byte_valid"};
        if (out_data.byte_index != want.byte_index) bad = {bad, " byte_index"};
        if (out_data.done_res != want.done_res) bad = {bad, " done_res"};
        if (out_data.status != want.status) bad = {bad, " status"};
        if (bad != "") begin
          report_fail($sformatf("mismatch in%s\n  exp %s\n  got %s",
                                bad, show_result(want), show_result(out_data)));
        end
      end
      if (out_data.byte_valid) begin
        bytes_seen++;
      end
      if (out_data.done_res) begin
        status_seen[out_data.status]++;
      end
    end
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("run timed out with %0d results outstanding", pending_results.size());
    $display("sd_cmd_line_engine_top verification failed");
    $finish;
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    idle_on  = 1'b1;
    stall_on = 1'b1;
    reset_line_engine();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_ticks();
    test_abandon_no_response();
    test_short_responses();
    test_long_response();
    test_start_timeout();
    test_drain_pause();
    test_full_rate();

    // let the last results drain, then a few quiet cycles
    wait_drained();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_fail($sformatf("%0d predicted results never arrived", pending_results.size()));
    end

    $display("covered %0d transactions over %0d commands, %0d response bytes captured",
             items_sent, commands_sent, bytes_seen);
    $display("completions: ok %0d, card busy %0d, start timeout %0d, crc error %0d; %0d failures",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], fail_count);
    if (fail_count == 0) begin
      $display("sd_cmd_line_engine_top verification clean");
    end else begin
      $display("sd_cmd_line_engine_top verification failed");
    end
    $finish;
  end

endmodule
